// File: hw/rtl/xnvs_pkg.sv
// Shared types and codes for the xor nearest value set unit.
// No dependencies; used by xnvs_ctrl, xnvs_datapath and the top level.
package xnvs_pkg;

    localparam int FIELD_W = 10;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAULT = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic              start_upd;
        logic              start_qry;
        logic              step_upd;
        logic              step_qry;
        logic              dec;
        logic              clear;
        logic              load_out;
        logic              hit;
        logic [STAT_W-1:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic total_full;
        logic total_zero;
        logic rd_zero;
        logic at_leaf;
        logic last_up;
        logic clr_last;
    } t_stat;

endpackage

// File: hw/rtl/xnvs_ctrl.sv
// Control state machine for the xor nearest value set unit.
// Depends on xnvs_pkg (t_cmd, t_stat, function and status codes).
module xnvs_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [xnvs_pkg::FUNC_W-1:0]     i_func,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_ready,
    input  xnvs_pkg::t_stat                 i_stat,
    output xnvs_pkg::t_cmd                  o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_UPD   = 5'b00100,
        S_QRY   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_is_rem, n_is_rem;
    logic                          r_hit, n_hit;
    logic [xnvs_pkg::STAT_W-1:0]   r_status, n_status;
    logic                          r_out_valid, n_out_valid;

    always_comb begin
        n_state   = r_state;
        n_is_rem  = r_is_rem;
        n_hit     = r_hit;
        n_status  = r_status;
        o_cmd     = '0;
        o_ready   = 1'b0;
        o_cmd.dec = r_is_rem;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_hit    = 1'b0;
                    n_status = xnvs_pkg::STAT_OK;
                    case (i_func)
                        xnvs_pkg::FUNC_INSERT: begin
                            if (i_stat.total_full) begin
                                n_status = xnvs_pkg::STAT_FAULT;
                                n_state  = S_FIN;
                            end else begin
                                o_cmd.start_upd = 1'b1;
                                n_is_rem        = 1'b0;
                                n_state         = S_UPD;
                            end
                        end
                        xnvs_pkg::FUNC_REMOVE: begin
                            o_cmd.start_upd = 1'b1;
                            n_is_rem        = 1'b1;
                            n_state         = S_UPD;
                        end
                        xnvs_pkg::FUNC_QUERY: begin
                            if (i_stat.total_zero) begin
                                n_status = xnvs_pkg::STAT_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                o_cmd.start_qry = 1'b1;
                                n_state         = S_QRY;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_UPD: begin
                // leaf count is checked before anything is written
                if (r_is_rem && i_stat.at_leaf && i_stat.rd_zero) begin
                    n_status = xnvs_pkg::STAT_FAULT;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.step_upd = 1'b1;
                    if (i_stat.last_up) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_QRY: begin
                o_cmd.step_qry = 1'b1;
                if (i_stat.at_leaf) begin
                    n_hit   = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.hit    = r_hit;
        o_cmd.status = r_status;
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_is_rem    <= 1'b0;
            r_hit       <= 1'b0;
            r_status    <= xnvs_pkg::STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_rem    <= n_is_rem;
            r_hit       <= n_hit;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/xnvs_datapath.sv
// Datapath: prefix count memory, last index memory, tree walk and result registers.
// Depends on xnvs_pkg (t_cmd, t_stat, field widths).
module xnvs_datapath #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_ITEMS  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [xnvs_pkg::FIELD_W-1:0]      i_value,
    input  logic [xnvs_pkg::FIELD_W-1:0]      i_item_index,
    input  xnvs_pkg::t_cmd                    i_cmd,
    output xnvs_pkg::t_stat                   o_stat,
    output logic [xnvs_pkg::FIELD_W-1:0]      o_found_index,
    output logic [xnvs_pkg::FIELD_W-1:0]      o_found_value,
    output logic [xnvs_pkg::FIELD_W-1:0]      o_xor_distance,
    output logic [xnvs_pkg::STAT_W-1:0]       o_status
);

    localparam int VB    = VALUE_BITS;
    localparam int FW    = xnvs_pkg::FIELD_W;
    localparam int NW    = VB + 1;
    localparam int NODES = 2 ** NW;
    localparam int LEAVES = 2 ** VB;
    localparam int CW    = $clog2(MAX_ITEMS + 1);

    // node k has children 2k and 2k+1; root count lives in r_total
    logic [CW-1:0] r_cnt_mem  [NODES];
    logic [FW-1:0] r_lidx_mem [LEAVES];

    logic [NW-1:0] r_node, n_node;
    logic [VB-1:0] r_value, n_value;
    logic [VB-1:0] r_shift, n_shift;
    logic [FW-1:0] r_item, n_item;
    logic [CW-1:0] r_rdata;
    logic [CW-1:0] r_total, n_total;
    logic [NW-1:0] r_clr_addr;
    logic [FW-1:0] r_lidx;

    logic [FW-1:0] r_found_index, r_found_value, r_xor_distance;
    logic [xnvs_pkg::STAT_W-1:0] r_status;

    logic [VB+FW-1:0] v_ext;
    logic [VB-1:0]    v_in;
    logic [NW-1:0]    chosen;
    logic             rd_en, wr_en, lidx_wr, lidx_rd;
    logic [NW-1:0]    rd_addr, wr_addr;
    logic [CW-1:0]    wr_data;
    logic [VB-1:0]    leaf;
    logic [VB-1:0]    xdist;
    logic [VB+FW-1:0] leaf_ext, dist_ext;

    assign v_ext = {{VB{1'b0}}, i_value};
    assign v_in  = v_ext[VB-1:0];

    // keep the same-bit child if occupied, else its sibling
    assign chosen = (r_rdata != '0) ? r_node : {r_node[NW-1:1], ~r_node[0]};

    always_comb begin
        n_node  = r_node;
        n_value = r_value;
        n_shift = r_shift;
        n_item  = r_item;
        n_total = r_total;
        rd_en   = 1'b0;
        rd_addr = {1'b0, r_node[NW-1:1]};
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = i_cmd.dec ? (r_rdata - CW'(1)) : (r_rdata + CW'(1));
        lidx_wr = 1'b0;
        lidx_rd = 1'b0;
        if (i_cmd.start_upd) begin
            rd_en   = 1'b1;
            rd_addr = {1'b1, v_in};
            n_node  = {1'b1, v_in};
            n_value = v_in;
            n_item  = i_item_index;
        end
        if (i_cmd.start_qry) begin
            rd_en   = 1'b1;
            rd_addr = {{(NW-2){1'b0}}, 1'b1, v_in[VB-1]};
            n_node  = rd_addr;
            n_value = v_in;
            n_shift = v_in << 1;
        end
        if (i_cmd.step_upd) begin
            // write this level, read its parent; bottom-up walk
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            n_node  = rd_addr;
            lidx_wr = r_node[NW-1] && !i_cmd.dec;
            if (o_stat.last_up) begin
                n_total = i_cmd.dec ? (r_total - CW'(1)) : (r_total + CW'(1));
            end
        end
        if (i_cmd.step_qry) begin
            if (chosen[NW-1]) begin
                lidx_rd = 1'b1;
                n_node  = chosen;
            end else begin
                rd_en   = 1'b1;
                rd_addr = {chosen[NW-2:0], r_shift[VB-1]};
                n_node  = rd_addr;
                n_shift = r_shift << 1;
            end
        end
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end
    end

    assign o_stat.total_full = (r_total == CW'(MAX_ITEMS));
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.rd_zero    = (r_rdata == '0);
    assign o_stat.at_leaf    = r_node[NW-1];
    assign o_stat.last_up    = (r_node[NW-1:1] == (NW-1)'(1));
    assign o_stat.clr_last   = &r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cnt_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lidx_wr) begin
            r_lidx_mem[r_node[VB-1:0]] <= r_item;
        end
        if (lidx_rd) begin
            r_lidx <= r_lidx_mem[chosen[VB-1:0]];
        end
    end

    assign leaf     = r_node[VB-1:0];
    assign xdist    = leaf ^ r_value;
    assign leaf_ext = {{FW{1'b0}}, leaf};
    assign dist_ext = {{FW{1'b0}}, xdist};

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_value <= n_value;
        r_shift <= n_shift;
        r_item  <= n_item;
        if (i_cmd.load_out) begin
            r_status       <= i_cmd.status;
            r_found_index  <= i_cmd.hit ? r_lidx : '0;
            r_found_value  <= i_cmd.hit ? leaf_ext[FW-1:0] : '0;
            r_xor_distance <= i_cmd.hit ? dist_ext[FW-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_clr_addr <= '0;
        end else begin
            r_total <= n_total;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + NW'(1);
            end
        end
    end

    assign o_found_index  = r_found_index;
    assign o_found_value  = r_found_value;
    assign o_xor_distance = r_xor_distance;
    assign o_status       = r_status;

endmodule

// File: hw/rtl/xor_nearest_value_set_unit.sv
// Top level of the xor nearest value set unit: binary prefix tree of counts.
// Depends on xnvs_pkg, xnvs_ctrl and xnvs_datapath.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_func, i_value, i_item_index
//   result   out        o_valid / i_ready   o_found_index, o_found_value,
//                                           o_xor_distance, o_status
//
// A refused insert, a query of an empty set and unused codes go straight from idle
// to the final state; a remove of an absent value ends at its leaf before anything is
// written. After reset a clearing pass zeroes the counts, o_ready stays low meanwhile.
// The query walk reads the count memory once per tree level, an update walk reads and
// writes each level. A new beat is taken while a result waits; the next result stalls in
// the final state until the output register drains.
module xor_nearest_value_set_unit #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_ITEMS  = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [xnvs_pkg::FUNC_W-1:0]    i_func,
    input  logic [xnvs_pkg::FIELD_W-1:0]   i_value,
    input  logic [xnvs_pkg::FIELD_W-1:0]   i_item_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [xnvs_pkg::FIELD_W-1:0]   o_found_index,
    output logic [xnvs_pkg::FIELD_W-1:0]   o_found_value,
    output logic [xnvs_pkg::FIELD_W-1:0]   o_xor_distance,
    output logic [xnvs_pkg::STAT_W-1:0]    o_status
);

    xnvs_pkg::t_cmd  cmd;
    xnvs_pkg::t_stat stat;

    xnvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    xnvs_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_item_index   (i_item_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_found_index  (o_found_index),
        .o_found_value  (o_found_value),
        .o_xor_distance (o_xor_distance),
        .o_status       (o_status)
    );

    // no new beat while counts are being cleared
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !o_ready)
        else $error("input ready during clearing pass");

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_valid || i_ready))
        else $error("result register overwritten");

    // one beat at a time: the unit leaves idle right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat accepted during an operation");

    // failed operations carry zero payload
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != xnvs_pkg::STAT_OK)) |->
        (o_found_index == '0 && o_found_value == '0 && o_xor_distance == '0))
        else $error("nonzero payload on error status");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for xor_nearest_value_set_unit: directed, back-pressure, random and
// drain operation streams, each result checked against a behavioral count tree.
// Depends on xnvs_pkg and the RTL of the unit.
module testbench;

    localparam int VALUE_BITS = 10;
    localparam int MAX_ITEMS  = 1024;
    localparam int LEAVES     = 1 << VALUE_BITS;
    localparam int RANDOM_OPS = 500;
    localparam int FW         = xnvs_pkg::FIELD_W;
    // unused code, block answers all zero
    localparam logic [xnvs_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [xnvs_pkg::FIELD_W-1:0] idx;
        logic [xnvs_pkg::FIELD_W-1:0] key;
        logic [xnvs_pkg::FIELD_W-1:0] xdist;
        logic [xnvs_pkg::STAT_W-1:0]  status;
    } t_lookup;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          o_ready;
    logic [xnvs_pkg::FUNC_W-1:0]   i_func       = '0;
    logic [xnvs_pkg::FIELD_W-1:0]  i_value      = '0;
    logic [xnvs_pkg::FIELD_W-1:0]  i_item_index = '0;
    logic                          o_valid;
    logic                          i_ready      = 1'b0;
    logic [xnvs_pkg::FIELD_W-1:0]  o_found_index;
    logic [xnvs_pkg::FIELD_W-1:0]  o_found_value;
    logic [xnvs_pkg::FIELD_W-1:0]  o_xor_distance;
    logic [xnvs_pkg::STAT_W-1:0]   o_status;

    // behavioral copy of the tree: node 1 is the root, leaf of v is LEAVES + v
    int unsigned                   node_count [1:2*LEAVES-1] = '{default: 0};
    logic [xnvs_pkg::FIELD_W-1:0]  leaf_tag   [0:LEAVES-1];
    t_lookup                       pending_q  [$];
    int                            fail_count = 0;
    int                            burst_left = 0;
    int                            hold_req   = 0;

    xor_nearest_value_set_unit #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_item_index   (i_item_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found_index  (o_found_index),
        .o_found_value  (o_found_value),
        .o_xor_distance (o_xor_distance),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned tree_node(int unsigned key, int unsigned lvl);
        return (1 << lvl) | (key >> (VALUE_BITS - lvl));
    endfunction

    // Applies one operation to the tree copy and queues the result it must give.
    function automatic void predict_lookup(logic [xnvs_pkg::FUNC_W-1:0] op,
                                           logic [xnvs_pkg::FIELD_W-1:0] key,
                                           logic [xnvs_pkg::FIELD_W-1:0] tag);
        t_lookup     r;
        int unsigned k, node, same, leaf;
        r = '0;
        k = 32'(key);
        case (op)
            xnvs_pkg::FUNC_INSERT: begin
                if (node_count[1] >= MAX_ITEMS) begin
                    r.status = xnvs_pkg::STAT_FAULT;
                end else begin
                    for (int lvl = 0; lvl <= VALUE_BITS; lvl++)
                        node_count[tree_node(k, lvl)]++;
                    leaf_tag[k] = tag;
                end
            end
            xnvs_pkg::FUNC_REMOVE: begin
                if (node_count[LEAVES + k] == 0) begin
                    r.status = xnvs_pkg::STAT_FAULT;
                end else begin
                    for (int lvl = 0; lvl <= VALUE_BITS; lvl++)
                        node_count[tree_node(k, lvl)]--;
                end
            end
            xnvs_pkg::FUNC_QUERY: begin
                if (node_count[1] == 0) begin
                    r.status = xnvs_pkg::STAT_EMPTY;
                end else begin
                    node = 1;
                    for (int lvl = 0; lvl < VALUE_BITS; lvl++) begin
                        same = (node << 1) | ((k >> (VALUE_BITS - 1 - lvl)) & 1);
                        node = (node_count[same] != 0) ? same : (same ^ 1);
                    end
                    leaf    = node - LEAVES;
                    r.idx   = leaf_tag[leaf];
                    r.key   = FW'(leaf);
                    r.xdist = FW'(leaf ^ k);
                end
            end
            default: ;
        endcase
        pending_q.insert(pending_q.size(), r);
    endfunction

    // random value currently in the set (random value if the set is empty)
    function automatic logic [xnvs_pkg::FIELD_W-1:0] pick_stored();
        int unsigned start, v;
        start = $urandom_range(0, LEAVES - 1);
        for (int i = 0; i < LEAVES; i++) begin
            v = (start + i) % LEAVES;
            if (node_count[LEAVES + v] != 0)
                return FW'(v);
        end
        return FW'(start);
    endfunction

    function automatic logic [xnvs_pkg::FIELD_W-1:0] near_stored();
        return pick_stored() ^
               FW'($urandom_range(0, LEAVES - 1) >> $urandom_range(2, VALUE_BITS));
    endfunction

    function automatic logic [xnvs_pkg::FIELD_W-1:0] any_value();
        return FW'($urandom_range(0, LEAVES - 1));
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_op(input logic [xnvs_pkg::FUNC_W-1:0] op,
                           input logic [xnvs_pkg::FIELD_W-1:0] key,
                           input logic [xnvs_pkg::FIELD_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid      <= 1'b1;
        i_func       <= op;
        i_value      <= key;
        i_item_index <= tag;
        do @(posedge i_clk); while (!o_ready);
        predict_lookup(op, key, tag);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_valid   <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_op(xnvs_pkg::FUNC_QUERY,  10'h155, 10'h000);   // query of empty set
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h000, 10'h3ff);   // remove of absent value
        send_op(FUNC_NONE,             10'h3ff, 10'h3ff);
        send_op(xnvs_pkg::FUNC_INSERT, 10'h000, 10'h000);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h3ff, 10'h3ff);   // single entry, largest distance
        send_op(xnvs_pkg::FUNC_INSERT, 10'h3ff, 10'h3ff);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h155, 10'h000);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h2aa, 10'h3ff);
        send_op(xnvs_pkg::FUNC_INSERT, 10'h2aa, 10'h155);
        send_op(xnvs_pkg::FUNC_INSERT, 10'h2aa, 10'h2aa);   // repeated insert keeps newest index
        send_op(xnvs_pkg::FUNC_QUERY,  10'h2ab, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h2aa, 10'h3ff);   // one copy still present
        send_op(xnvs_pkg::FUNC_QUERY,  10'h2aa, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h2aa, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h2aa, 10'h000);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h2aa, 10'h000);
        send_op(FUNC_NONE,             10'h000, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h3ff, 10'h000);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h000, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h000, 10'h000);
        send_op(xnvs_pkg::FUNC_QUERY,  10'h3ff, 10'h000);
        send_op(xnvs_pkg::FUNC_REMOVE, 10'h000, 10'h000);
        end_burst();
    endtask

    // receiver holds off long enough for the unit to fill and drop o_ready
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_req++;
        @(negedge i_clk);
        repeat (6) send_op(xnvs_pkg::FUNC_INSERT, any_value(), any_value());
        repeat (10) send_op(xnvs_pkg::FUNC_QUERY, any_value(), any_value());
        end_burst();
    endtask

    task automatic test_random_mix();
        int done, roll, grow, ins_w, rem_w;
        done = 0;
        grow = 1;
        while (done < RANDOM_OPS) begin
            if (done % 100 == 0)
                grow = $urandom_range(0, 1);
            ins_w = grow ? 50 : 20;
            rem_w = grow ? 15 : 45;
            roll  = $urandom_range(0, 99);
            if (roll < 4) begin
                send_op(FUNC_NONE, any_value(), any_value());
            end else begin
                if (roll < 4 + ins_w)
                    send_op(xnvs_pkg::FUNC_INSERT,
                            $urandom_range(0, 1) ? any_value() : near_stored(),
                            any_value());
                else if (roll < 4 + ins_w + rem_w)
                    send_op(xnvs_pkg::FUNC_REMOVE,
                            ($urandom_range(0, 6) != 0) ? pick_stored() : any_value(),
                            any_value());
                else
                    send_op(xnvs_pkg::FUNC_QUERY,
                            $urandom_range(0, 1) ? any_value() : near_stored(),
                            any_value());
                done++;
            end
        end
        end_burst();
    endtask

    task automatic test_drain();
        while (node_count[1] != 0) begin
            if ($urandom_range(0, 7) == 0)
                send_op(xnvs_pkg::FUNC_QUERY, any_value(), any_value());
            else
                send_op(xnvs_pkg::FUNC_REMOVE, pick_stored(), any_value());
        end
        send_op(xnvs_pkg::FUNC_QUERY, any_value(), any_value());
        end_burst();
    endtask

    // receiver: stall pattern is redrawn from four modes whenever its phase runs out
    initial begin : result_sink
        int mode, phase, hold_left, hold_seen;
        mode      = 0;
        phase     = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (phase == 0) begin
                mode  = $urandom_range(0, 3);
                phase = $urandom_range(16, 96);
            end
            phase--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_ready <= (phase % 3 == 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lookup got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_found_index, o_found_value, o_xor_distance, o_status};
            if (pending_q.size() == 0) begin
                note_failure($sformatf("unexpected beat: idx %0d value %0d dist %0d status %0d",
                                       got.idx, got.key, got.xdist, got.status));
            end else begin
                want = pending_q.pop_front();
                if (got.idx !== want.idx || got.key !== want.key ||
                    got.xdist !== want.xdist || got.status !== want.status)
                    note_failure($sformatf(
                        "mismatch: exp idx %0d value %0d dist %0d status %0d, got %0d %0d %0d %0d",
                        want.idx, want.key, want.xdist, want.status,
                        got.idx, got.key, got.xdist, got.status));
            end
        end
    end

    initial begin : watchdog
        #6_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin : main_seq
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_mix();
        test_drain();
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
